// ===== rtl/hns_pkg.sv =====
// Shared types and constants for the height-field normal pipeline.
package hns_pkg;

	// Grid geometry and field widths.
	localparam int GRID_SIZE = 256;
	localparam int COORD_W   = 8;
	localparam int HEIGHT_W  = 16;
	localparam int SPACING_W = 16;
	localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd1024;

	// Normalization datapath widths.
	localparam int MAG_W  = 16;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int LEN_W  = SQ_W + 2;
	localparam int QUO_W  = 31;
	localparam int RAD_W  = QUO_W + 1;
	localparam int ROOT_W = 16;
	localparam int SREM_W = ROOT_W + 2;
	localparam int Q_W    = 15;

	// Step counts of the divider and the square root in each lane.
	localparam int DIV_STEPS   = QUO_W;
	localparam int SQRT_STEPS  = RAD_W / 2;
	localparam int LANE_STAGES = DIV_STEPS + SQRT_STEPS + 1;

	// One input item.
	typedef struct packed {
		logic signed [HEIGHT_W-1:0] height;
		logic [COORD_W-1:0]         row;
		logic [COORD_W-1:0]         col;
	} sample_t;

	// One result item.
	typedef struct packed {
		logic signed [15:0] normal_x;
		logic [Q_W-1:0]     normal_y;
		logic signed [15:0] normal_z;
		logic [COORD_W-1:0] center_row;
		logic [COORD_W-1:0] center_col;
	} normal_t;

	// Stencil taps: three read from the line stores, plus the new sample's height.
	typedef struct packed {
		logic                       valid;
		logic signed [HEIGHT_W-1:0] up;
		logic signed [HEIGHT_W-1:0] left;
		logic signed [HEIGHT_W-1:0] right;
		logic signed [HEIGHT_W-1:0] down;
		logic [COORD_W-1:0]         row;
		logic [COORD_W-1:0]         col;
	} taps_t;

	// Item state handed from the front end to the lanes.
	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] center_row;
		logic [COORD_W-1:0] center_col;
		logic               neg_x;
		logic               neg_z;
		logic [SQ_W-1:0]    sq_x;
		logic [SQ_W-1:0]    sq_y;
		logic [SQ_W-1:0]    sq_z;
		logic [LEN_W-1:0]   len;
	} front_t;

	// Per-item tags that ride alongside the lanes.
	typedef struct packed {
		logic [COORD_W-1:0] center_row;
		logic [COORD_W-1:0] center_col;
		logic               neg_x;
		logic               neg_z;
	} meta_t;

endpackage

// ===== rtl/hns_line_buf.sv =====
// Two-row line stores with forwarding, producing the four stencil taps.
module hns_line_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             take,
	input  hns_pkg::sample_t sample,
	output hns_pkg::taps_t   taps
);

	// Each store is kept twice so that every copy has a single read port.
	logic [hns_pkg::HEIGHT_W-1:0] older_a_mem [hns_pkg::GRID_SIZE];
	logic [hns_pkg::HEIGHT_W-1:0] older_b_mem [hns_pkg::GRID_SIZE];
	logic [hns_pkg::HEIGHT_W-1:0] newer_a_mem [hns_pkg::GRID_SIZE];
	logic [hns_pkg::HEIGHT_W-1:0] newer_b_mem [hns_pkg::GRID_SIZE];

	logic                          valid_s1;
	logic [hns_pkg::HEIGHT_W-1:0]  h_s1;
	logic [hns_pkg::COORD_W-1:0]   row_s1;
	logic [hns_pkg::COORD_W-1:0]   col_s1;
	logic [hns_pkg::HEIGHT_W-1:0]  up_rd_s1;
	logic [hns_pkg::HEIGHT_W-1:0]  left_rd_s1;
	logic [hns_pkg::HEIGHT_W-1:0]  right_rd_s1;
	logic [hns_pkg::HEIGHT_W-1:0]  newer_rd_s1;
	logic [hns_pkg::HEIGHT_W-1:0]  fwd_data_s1;
	logic                          fwd_up_s1;
	logic                          fwd_left_s1;
	logic [hns_pkg::COORD_W-1:0]   col_m1;
	logic [hns_pkg::COORD_W-1:0]   col_p1;

	assign col_m1 = sample.col - hns_pkg::COORD_W'(1);
	assign col_p1 = sample.col + hns_pkg::COORD_W'(1);

	// The new height lands in the newer row as the item is accepted.
	always_ff @(posedge clk) begin
		if (take) begin
			newer_a_mem[sample.col] <= sample.height;
			newer_b_mem[sample.col] <= sample.height;
		end
		if (valid_s1) begin
			older_a_mem[col_s1] <= newer_rd_s1;
			older_b_mem[col_s1] <= newer_rd_s1;
		end
	end

	// Reads happen whenever the pipeline advances; a pending older-row write is forwarded.
	always_ff @(posedge clk) begin
		if (en) begin
			up_rd_s1    <= older_a_mem[sample.col];
			left_rd_s1  <= older_b_mem[col_m1];
			right_rd_s1 <= newer_a_mem[col_p1];
			newer_rd_s1 <= newer_b_mem[sample.col];
			fwd_data_s1 <= newer_rd_s1;
			fwd_up_s1   <= valid_s1 && (col_s1 == sample.col);
			fwd_left_s1 <= valid_s1 && (col_s1 == col_m1);
			h_s1        <= sample.height;
			row_s1      <= sample.row;
			col_s1      <= sample.col;
		end
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= take;
		end
	end

	// Tap selection.
	always_comb begin
		taps.valid = valid_s1;
		taps.up    = fwd_up_s1 ? fwd_data_s1 : up_rd_s1;
		taps.left  = fwd_left_s1 ? fwd_data_s1 : left_rd_s1;
		taps.right = right_rd_s1;
		taps.down  = h_s1;
		taps.row   = row_s1;
		taps.col   = col_s1;
	end

endmodule

// ===== rtl/hns_front.sv =====
// Differences, magnitudes, squares and squared length of the normal vector.
module hns_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  hns_pkg::taps_t                    taps,
	input  logic [hns_pkg::SPACING_W-1:0]     spacing,
	output hns_pkg::front_t                   front
);

	logic signed [hns_pkg::HEIGHT_W:0] dx;
	logic signed [hns_pkg::HEIGHT_W:0] dz;
	logic [hns_pkg::HEIGHT_W:0]        abs_x;
	logic [hns_pkg::HEIGHT_W:0]        abs_z;
	logic [hns_pkg::SPACING_W-1:0]     s_eff;
	logic [hns_pkg::SPACING_W:0]       my_full;
	logic                              halve;
	logic                              interior;

	logic                              valid_s2, valid_s3, valid_s4;
	logic [hns_pkg::COORD_W-1:0]       row_s2, row_s3, row_s4;
	logic [hns_pkg::COORD_W-1:0]       col_s2, col_s3, col_s4;
	logic                              neg_x_s2, neg_x_s3, neg_x_s4;
	logic                              neg_z_s2, neg_z_s3, neg_z_s4;
	logic [hns_pkg::MAG_W-1:0]         mx_s2, my_s2, mz_s2;
	logic [hns_pkg::SQ_W-1:0]          sqx_s3, sqy_s3, sqz_s3;
	logic [hns_pkg::SQ_W-1:0]          sqx_s4, sqy_s4, sqz_s4;
	logic [hns_pkg::LEN_W-1:0]         len_s4;

	// Vector components as sign and magnitude, halved when the spacing term overflows.
	always_comb begin
		dx       = {taps.up[hns_pkg::HEIGHT_W-1], taps.up}
		         - {taps.down[hns_pkg::HEIGHT_W-1], taps.down};
		dz       = {taps.left[hns_pkg::HEIGHT_W-1], taps.left}
		         - {taps.right[hns_pkg::HEIGHT_W-1], taps.right};
		abs_x    = dx[hns_pkg::HEIGHT_W] ? -dx : dx;
		abs_z    = dz[hns_pkg::HEIGHT_W] ? -dz : dz;
		s_eff    = (spacing == '0) ? hns_pkg::SPACING_W'(1) : spacing;
		my_full  = {s_eff, 1'b0};
		halve    = my_full[hns_pkg::SPACING_W];
		interior = (taps.row >= hns_pkg::COORD_W'(2)) && (taps.col != '0)
		         && ({1'b0, taps.col} <= (hns_pkg::COORD_W + 1)'(hns_pkg::GRID_SIZE - 2));
	end

	// Stage 2: magnitudes.
	always_ff @(posedge clk) begin
		if (en) begin
			row_s2   <= taps.row - hns_pkg::COORD_W'(1);
			col_s2   <= taps.col;
			neg_x_s2 <= dx[hns_pkg::HEIGHT_W];
			neg_z_s2 <= dz[hns_pkg::HEIGHT_W];
			mx_s2    <= halve ? abs_x[hns_pkg::MAG_W:1] : abs_x[hns_pkg::MAG_W-1:0];
			my_s2    <= halve ? my_full[hns_pkg::MAG_W:1] : my_full[hns_pkg::MAG_W-1:0];
			mz_s2    <= halve ? abs_z[hns_pkg::MAG_W:1] : abs_z[hns_pkg::MAG_W-1:0];
		end
	end

	// Stage 3: squares.
	always_ff @(posedge clk) begin
		if (en) begin
			row_s3   <= row_s2;
			col_s3   <= col_s2;
			neg_x_s3 <= neg_x_s2;
			neg_z_s3 <= neg_z_s2;
			sqx_s3   <= mx_s2 * mx_s2;
			sqy_s3   <= my_s2 * my_s2;
			sqz_s3   <= mz_s2 * mz_s2;
		end
	end

	// Stage 4: squared length.
	always_ff @(posedge clk) begin
		if (en) begin
			row_s4   <= row_s3;
			col_s4   <= col_s3;
			neg_x_s4 <= neg_x_s3;
			neg_z_s4 <= neg_z_s3;
			sqx_s4   <= sqx_s3;
			sqy_s4   <= sqy_s3;
			sqz_s4   <= sqz_s3;
			len_s4   <= hns_pkg::LEN_W'(sqx_s3) + hns_pkg::LEN_W'(sqy_s3)
			          + hns_pkg::LEN_W'(sqz_s3);
		end
	end

	// Valid bits; border points are dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s2 <= taps.valid && interior;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		front.valid      = valid_s4;
		front.center_row = row_s4;
		front.center_col = col_s4;
		front.neg_x      = neg_x_s4;
		front.neg_z      = neg_z_s4;
		front.sq_x       = sqx_s4;
		front.sq_y       = sqy_s4;
		front.sq_z       = sqz_s4;
		front.len        = len_s4;
	end

endmodule

// ===== rtl/hns_norm_lane.sv =====
// One normalization lane: pipelined restoring divide, then pipelined square root.
module hns_norm_lane (
	input  logic                          clk,
	input  logic                          en,
	input  logic [hns_pkg::SQ_W-1:0]      sq,
	input  logic [hns_pkg::LEN_W-1:0]     len,
	output logic [hns_pkg::Q_W-1:0]       q
);

	localparam int LW = hns_pkg::LEN_W;
	localparam int QW = hns_pkg::QUO_W;
	localparam int RW = hns_pkg::RAD_W;
	localparam int TW = hns_pkg::ROOT_W;
	localparam int SW = hns_pkg::SREM_W;

	logic [LW-1:0] rem_s  [hns_pkg::DIV_STEPS];
	logic [LW-1:0] len_s  [hns_pkg::DIV_STEPS];
	logic [QW-1:0] quo_s  [hns_pkg::DIV_STEPS];
	logic [RW-1:0] rad_s  [hns_pkg::SQRT_STEPS];
	logic [SW-1:0] srem_s [hns_pkg::SQRT_STEPS];
	logic [TW-1:0] root_s [hns_pkg::SQRT_STEPS];
	logic [hns_pkg::Q_W-1:0] q_s;
	logic [TW:0]   root_inc;
	logic [LW-1:0] sq_ext;
	logic          first_ge;

	// First quotient bit: the ratio of a square to the length is at most one.
	assign sq_ext   = LW'(sq);
	assign first_ge = sq_ext >= len;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= first_ge ? (sq_ext - len) : sq_ext;
			len_s[0] <= len;
			quo_s[0] <= QW'(first_ge);
		end
	end

	// Remaining quotient bits, one per stage.
	for (genvar k = 1; k < hns_pkg::DIV_STEPS; k++) begin : g_div
		logic [LW:0] dbl;
		logic        ge;
		assign dbl = {rem_s[k-1], 1'b0};
		assign ge  = dbl >= {1'b0, len_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? LW'(dbl - {1'b0, len_s[k-1]}) : dbl[LW-1:0];
				len_s[k] <= len_s[k-1];
				quo_s[k] <= {quo_s[k-1][QW-2:0], ge};
			end
		end
	end

	// Integer square root of the quotient, two radicand bits per stage.
	for (genvar j = 0; j < hns_pkg::SQRT_STEPS; j++) begin : g_sqrt
		logic [RW-1:0] rad_i;
		logic [SW-1:0] rem_i;
		logic [TW-1:0] root_i;
		logic [SW+1:0] cur;
		logic [SW+1:0] trial;
		logic          ge;
		if (j == 0) begin : g_first
			assign rad_i  = {1'b0, quo_s[hns_pkg::DIV_STEPS-1]};
			assign rem_i  = '0;
			assign root_i = '0;
		end else begin : g_next
			assign rad_i  = rad_s[j-1];
			assign rem_i  = srem_s[j-1];
			assign root_i = root_s[j-1];
		end
		assign cur   = {rem_i, rad_i[RW-1:RW-2]};
		assign trial = (SW + 2)'({root_i, 2'b01});
		assign ge    = cur >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j]  <= {rad_i[RW-3:0], 2'b00};
				srem_s[j] <= ge ? SW'(cur - trial) : cur[SW-1:0];
				root_s[j] <= {root_i[TW-2:0], ge};
			end
		end
	end

	// The largest odd number not above the root gives the rounded magnitude.
	assign root_inc = {1'b0, root_s[hns_pkg::SQRT_STEPS-1]} + (TW + 1)'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s <= root_inc[hns_pkg::Q_W:1];
		end
	end

	assign q = q_s;

endmodule

// ===== rtl/heightfield_normal_stencil_top.sv =====
// Top level of the streaming height-field surface normal unit.
//
// Takes one height sample per clock in raster order and, for each interior grid point,
// returns its unit normal in Q1.14 when the sample one row below arrives. An accepted
// sample passes the line-store read, the differencing, squaring and summing stages,
// then the normalization lanes, which hold a 31-step pipelined divider followed by a
// 16-step pipelined square root. A new item enters every cycle; when a result is held
// at the output the whole pipeline freezes, so items are never dropped or repeated.
// Border samples update the line stores but produce no result. The spacing register
// is written through cfg_valid and cfg_data and resets to 1024; the user must see that it
// is written only while the pipeline is empty; the block itself does not enforce this.
module heightfield_normal_stencil_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hns_pkg::SPACING_W-1:0]  cfg_data,
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  hns_pkg::sample_t               sample,
	output logic                           normal_valid,
	input  logic                           normal_ready,
	output hns_pkg::normal_t               normal
);

	logic                          en;
	logic                          take;
	logic [hns_pkg::SPACING_W-1:0] spacing_q;
	hns_pkg::taps_t                taps;
	hns_pkg::front_t               front;
	hns_pkg::meta_t                meta_s [hns_pkg::LANE_STAGES];
	logic                          meta_valid_s [hns_pkg::LANE_STAGES];
	logic [hns_pkg::Q_W-1:0]       qx, qy, qz;
	hns_pkg::meta_t                meta_out;

	// The pipeline advances whenever the output register is free or being taken.
	assign en           = !normal_valid || normal_ready;
	assign sample_ready = en;
	assign take         = sample_valid && en
	                    && ({1'b0, sample.row} < (hns_pkg::COORD_W + 1)'(hns_pkg::GRID_SIZE))
	                    && ({1'b0, sample.col} < (hns_pkg::COORD_W + 1)'(hns_pkg::GRID_SIZE));
	assign cfg_ready    = 1'b1;

	// Spacing register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= hns_pkg::SPACING_RESET;
		end else if (cfg_valid) begin
			spacing_q <= cfg_data;
		end
	end

	hns_line_buf u_line_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.take   (take),
		.sample (sample),
		.taps   (taps)
	);

	hns_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.taps    (taps),
		.spacing (spacing_q),
		.front   (front)
	);

	hns_norm_lane u_lane_x (.clk(clk), .en(en), .sq(front.sq_x), .len(front.len), .q(qx));
	hns_norm_lane u_lane_y (.clk(clk), .en(en), .sq(front.sq_y), .len(front.len), .q(qy));
	hns_norm_lane u_lane_z (.clk(clk), .en(en), .sq(front.sq_z), .len(front.len), .q(qz));

	// Item valid bits travel beside the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hns_pkg::LANE_STAGES; i++) begin
				meta_valid_s[i] <= 1'b0;
			end
		end else if (en) begin
			meta_valid_s[0] <= front.valid;
			for (int i = 1; i < hns_pkg::LANE_STAGES; i++) begin
				meta_valid_s[i] <= meta_valid_s[i-1];
			end
		end
	end

	// Item tags travel beside the lanes.
	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0].center_row <= front.center_row;
			meta_s[0].center_col <= front.center_col;
			meta_s[0].neg_x      <= front.neg_x;
			meta_s[0].neg_z      <= front.neg_z;
			for (int i = 1; i < hns_pkg::LANE_STAGES; i++) begin
				meta_s[i] <= meta_s[i-1];
			end
		end
	end

	// Result assembly with the component signs restored.
	assign meta_out     = meta_s[hns_pkg::LANE_STAGES-1];
	assign normal_valid = meta_valid_s[hns_pkg::LANE_STAGES-1];

	always_comb begin
		normal.normal_x   = meta_out.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
		normal.normal_y   = qy;
		normal.normal_z   = meta_out.neg_z ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
		normal.center_row = meta_out.center_row;
		normal.center_col = meta_out.center_col;
	end

endmodule

// ===== rtl/hns_checker.sv =====
// Port-level checks for the height-field normal unit, bound to the top level.
module hns_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_ready,
	input logic             normal_valid,
	input logic             normal_ready,
	input hns_pkg::normal_t normal
);

	// A held result stalls the input side.
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		normal_valid && !normal_ready |-> !sample_ready)
		else $error("input accepted while a result is held");

	// A held result keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		normal_valid && !normal_ready |=> normal_valid && $stable(normal))
		else $error("held result changed");

	// Results belong to interior columns only.
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		normal_valid |-> normal.center_col != '0
			&& ({1'b0, normal.center_col} <= 9'(hns_pkg::GRID_SIZE - 2)))
		else $error("result for a border column");

	// Components stay within unit range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		normal_valid |-> normal.normal_x >= -16'sd16384 && normal.normal_z >= -16'sd16384
			&& normal.normal_x <= 16'sd16384 && normal.normal_z <= 16'sd16384
			&& normal.normal_y <= 15'd16384)
		else $error("normal component out of range");

endmodule

bind heightfield_normal_stencil_top hns_checker u_hns_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_ready (sample_ready),
	.normal_valid (normal_valid),
	.normal_ready (normal_ready),
	.normal       (normal)
);

// ===== test/heightfield_normal_stencil_checker.sv =====
// Checker that predicts and compares the surface normals of the height-field unit.
module heightfield_normal_stencil_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [15:0]      cfg_data,
	input  logic             sample_valid,
	input  logic             sample_ready,
	input  hns_pkg::sample_t sample,
	input  logic             normal_valid,
	input  logic             normal_ready,
	input  hns_pkg::normal_t normal,
	output int               fail_count,
	output int               pending
);

	// Shadow copy of the spacing register and of both line stores.
	logic [15:0]      spacing;
	logic [15:0]      row_prev2 [hns_pkg::GRID_SIZE];
	logic [15:0]      row_prev1 [hns_pkg::GRID_SIZE];
	hns_pkg::normal_t normal_queue [$];

	// Largest q with (2q-1)^2 * len2 <= 2^30 * mag^2, found by bisection.
	function automatic logic [14:0] unit_mag(longint unsigned mag, longint unsigned len2);
		longint unsigned rhs;
		longint unsigned t;
		int unsigned     lo;
		int unsigned     hi;
		int unsigned     mid;
		rhs = (mag * mag) << 30;
		lo = 0;
		hi = 16384;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			t = 2 * longint'(mid) - 1;
			if (t * t * len2 <= rhs) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return lo[14:0];
	endfunction

	// Predict the normal for one sample and update the shadow line stores.
	task automatic predict_normal(input hns_pkg::sample_t s);
		int               up, left, right, down, dx, dz;
		longint unsigned  mx, my, mz, len2;
		logic [15:0]      qx, qz;
		hns_pkg::normal_t n;
		if (s.row >= 2 && s.col >= 1 && int'(s.col) + 2 <= hns_pkg::GRID_SIZE) begin
			up    = int'($signed(row_prev2[s.col]));
			left  = int'($signed(row_prev2[s.col - 1]));
			right = int'($signed(row_prev1[s.col + 1]));
			down  = int'(s.height);
			dx = up - down;
			dz = left - right;
			mx = (dx < 0) ? longint'(-dx) : longint'(dx);
			mz = (dz < 0) ? longint'(-dz) : longint'(dz);
			my = 2 * longint'((spacing == 0) ? 16'd1 : spacing);
			// Any magnitude past 16 bits scales the whole vector down by one bit.
			if (mx >= 65536 || my >= 65536 || mz >= 65536) begin
				mx = mx >> 1;
				my = my >> 1;
				mz = mz >> 1;
			end
			len2 = mx * mx + my * my + mz * mz;
			qx = {1'b0, unit_mag(mx, len2)};
			qz = {1'b0, unit_mag(mz, len2)};
			n.normal_x   = (dx < 0) ? -qx : qx;
			n.normal_y   = unit_mag(my, len2);
			n.normal_z   = (dz < 0) ? -qz : qz;
			n.center_row = s.row - hns_pkg::COORD_W'(1);
			n.center_col = s.col;
			normal_queue.push_back(n);
		end
		row_prev2[s.col] = row_prev1[s.col];
		row_prev1[s.col] = s.height;
	endtask

	assign pending = normal_queue.size();

	// Watch all three channels at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		hns_pkg::normal_t exp_n;
		if (!arst_n) begin
			spacing = hns_pkg::SPACING_RESET;
			fail_count = 0;
			normal_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				spacing = cfg_data;
			end
			if (sample_valid && sample_ready) begin
				predict_normal(sample);
			end
			if (normal_valid && normal_ready) begin
				if (normal_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected normal: x=%0d y=%0d z=%0d at (%0d,%0d)",
							normal.normal_x, normal.normal_y, normal.normal_z,
							normal.center_row, normal.center_col);
					end
				end else begin
					exp_n = normal_queue.pop_front();
					if (exp_n.normal_x !== normal.normal_x
						|| exp_n.normal_y !== normal.normal_y
						|| exp_n.normal_z !== normal.normal_z
						|| exp_n.center_row !== normal.center_row
						|| exp_n.center_col !== normal.center_col) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch: exp %0d %0d %0d (%0d,%0d) got %0d %0d %0d (%0d,%0d)",
								exp_n.normal_x, exp_n.normal_y, exp_n.normal_z,
								exp_n.center_row, exp_n.center_col,
								normal.normal_x, normal.normal_y, normal.normal_z,
								normal.center_row, normal.center_col);
						end
					end
				end
			end
		end
	end

endmodule

// ===== test/heightfield_normal_stencil_top_tb.sv =====
// Stimulus and verdict for the height-field normal unit.
module heightfield_normal_stencil_top_tb;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [15:0]      cfg_data;
	logic             sample_valid;
	logic             sample_ready;
	hns_pkg::sample_t sample;
	logic             normal_valid;
	logic             normal_ready;
	hns_pkg::normal_t normal;
	int               fail_count;
	int               pending;
	int               tx_idle;
	int               rx_idle;

	heightfield_normal_stencil_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.normal_valid (normal_valid),
		.normal_ready (normal_ready),
		.normal       (normal)
	);

	heightfield_normal_stencil_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.normal_valid (normal_valid),
		.normal_ready (normal_ready),
		.normal       (normal),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver stalls at random according to the current idle rate.
	always @(negedge clk) begin
		normal_ready <= ($urandom_range(99) >= rx_idle);
	end

	// Hard limit on the run.
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	// Send one sample item, idling beforehand at the sender rate.
	task automatic send_sample(input logic [15:0] h, input logic [7:0] r, input logic [7:0] c);
		while ($urandom_range(99) < tx_idle) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid  <= 1'b1;
		sample.height <= h;
		sample.row    <= r;
		sample.col    <= c;
		do @(posedge clk); while (!sample_ready);
		@(negedge clk);
	endtask

	// Drain the pipeline, then let border items run out before a register write.
	task automatic wait_idle();
		sample_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_spacing(input logic [15:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Pick a height: mostly random, sometimes an extreme or a small value.
	function automatic logic [15:0] pick_height();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(7)) - 16'd3;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] spacings [9];
		int          run_len;
		int          r;
		int          c;
		int          sent;
		tx_idle      = 0;
		rx_idle      = 0;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		sample_valid = 1'b0;
		sample       = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill both line stores so every later read hits a written entry.
		for (int rr = 0; rr < 2; rr++) begin
			for (int cc = 0; cc < hns_pkg::GRID_SIZE; cc++) begin
				send_sample(pick_height(), 8'(rr), 8'(cc));
			end
		end

		// Directed items at the reset spacing: border columns and extreme heights.
		send_sample(16'h7FFF, 8'd2, 8'd0);
		send_sample(16'h8000, 8'd2, 8'd1);
		send_sample(16'h7FFF, 8'd2, 8'd2);
		send_sample(16'h0000, 8'd2, 8'd3);
		send_sample(16'hFFFF, 8'd2, 8'd127);
		send_sample(16'h8000, 8'd2, 8'd254);
		send_sample(16'h7FFF, 8'd2, 8'd255);
		send_sample(16'h8000, 8'd3, 8'd2);
		send_sample(16'h7FFF, 8'd3, 8'd1);
		send_sample(16'h7FFF, 8'd3, 8'd3);
		send_sample(16'h0001, 8'd1, 8'd100);
		send_sample(16'h1234, 8'd255, 8'd254);
		send_sample(16'h8000, 8'd255, 8'd1);
		send_sample(16'h0000, 8'd255, 8'd255);
		send_sample(16'h0000, 8'd0, 8'd0);

		// Pause the sender until the pipeline is fully drained.
		wait_idle();

		spacings = '{16'd1, 16'd65535, 16'd0, 16'd1024, 16'd1, 16'd65535,
			16'($urandom_range(65535, 1)), 16'd256, 16'($urandom_range(65535, 1))};

		// Three idle regimes, three spacing settings in each.
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle = (phase == 0) ? 20 : (phase == 1) ? 52 : 0;
			rx_idle = (phase == 0) ? 52 : (phase == 1) ? 20 : 0;
			for (int k = 0; k < 3; k++) begin
				write_spacing(spacings[phase * 3 + k]);
				sent = 0;
				while (sent < 140) begin
					if ($urandom_range(9) == 0) begin
						// Noise: any position, borders and non-raster order included.
						send_sample(16'($urandom), 8'($urandom), 8'($urandom));
						sent++;
					end else begin
						// A raster run with random content, wrapping onto the next row at the last column.
						r = $urandom_range(255, 2);
						c = $urandom_range(255);
						run_len = $urandom_range(40, 1);
						for (int j = 0; j < run_len && sent < 140; j++) begin
							send_sample(pick_height(), 8'(r), 8'(c));
							sent++;
							c = (c + 1) % hns_pkg::GRID_SIZE;
							if (c == 0) begin
								r = (r == 255) ? 2 : r + 1;
							end
						end
					end
				end
			end
		end

		// Drain and settle, then give the verdict.
		sample_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
